/* rtl/dqf_pkg.sv */
// shared types and constants for the double-ended queue with fourth removal
package dqf_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int COUNT_OUT_W   = 5;

	// operation codes
	typedef enum logic [2:0] {
		OP_PUSH_FRONT    = 3'd0,
		OP_PUSH_BACK     = 3'd1,
		OP_POP_FRONT     = 3'd2,
		OP_POP_BACK      = 3'd3,
		OP_REMOVE_FOURTH = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_R4_A,
		S_R4_B,
		S_R4_C,
		S_R4_D,
		S_FINISH
	} state_t;

endpackage

/* rtl/dqf_ram.sv */
// entry store: one write port and one registered read port
module dqf_ram #(
	parameter int DEPTH = dqf_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [dqf_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [dqf_pkg::DATA_W-1:0] rdata
);

	logic [dqf_pkg::DATA_W-1:0] mem [DEPTH];
	logic [dqf_pkg::DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/deque_with_fourth_removal.sv */
// top level of the bounded double-ended queue with fourth-entry removal
// Bounded double-ended queue of signed 32-bit words held in a circular
// store of DEPTH entries (one write and one registered read port). Each
// request word carries an operation: push front, push back, pop front,
// pop back or remove the fourth entry from the front, and yields exactly
// one response word with the removed value, its valid mark, the count held
// afterwards (low five bits) and a status. One request is worked on at a
// time. A push, a rejected request or an unknown code goes from the
// accepting edge straight to the finish state; a pop first passes
// through S_POP_RD, and the fourth-entry removal through S_R4_A, S_R4_B,
// S_R4_C and S_R4_D, reading four entries and writing three back
// through the single memory port pair. The response register loads only
// once it is free or being emptied. The next request can be taken in
// the cycle after the response has moved into the output register, even
// if that response has not yet been taken downstream.
module deque_with_fourth_removal #(
	parameter int DEPTH = dqf_pkg::DEPTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  logic [2:0]                             operation,
	input  logic signed [dqf_pkg::DATA_W-1:0]      push_value,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output logic signed [dqf_pkg::DATA_W-1:0]      removed_value,
	output logic                                   removed_valid,
	output logic [dqf_pkg::COUNT_OUT_W-1:0]        entry_count,
	output logic [1:0]                             status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW:0]   SUM_DEPTH = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
	localparam logic [CW-1:0] CNT_MIN4  = CW'(3);
	localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);

	// circular index add, offset below DEPTH
	function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
		input logic [PW-1:0] off);
		logic [PW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= SUM_DEPTH) begin
			sum = sum - SUM_DEPTH;
		end
		return sum[PW-1:0];
	endfunction

	dqf_pkg::state_t state_q, state_d;
	logic [PW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [2:0]    op_q;

	logic [dqf_pkg::DATA_W-1:0] res_value_q, res_value_d;
	logic                       res_rvalid_q, res_rvalid_d;
	logic [1:0]                 res_status_q, res_status_d;
	logic                       res_load;

	logic                       rsp_valid_q;
	logic [dqf_pkg::DATA_W-1:0] rsp_value_q;
	logic                       rsp_rvalid_q;
	logic [dqf_pkg::COUNT_OUT_W-1:0] rsp_count_q;
	logic [1:0]                 rsp_status_q;
	logic                       rsp_load;

	logic                       accept;
	logic                       mem_we;
	logic [PW-1:0]              mem_waddr, mem_raddr;
	logic [dqf_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

	logic [PW-1:0] slot1, slot2, slot3, slot_prev, slot_cnt, slot_cntm1;
	logic [CW-1:0] count_m1;
	logic          is_full, is_empty, is_long;

	// storage
	dqf_ram #(
		.DEPTH (DEPTH),
		.AW    (PW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// addresses relative to the front
	assign count_m1   = count_q - CW'(1);
	assign slot1      = slot_add(front_q, PW'(1));
	assign slot2      = slot_add(front_q, PW'(2));
	assign slot3      = slot_add(front_q, PW'(3));
	assign slot_prev  = (front_q == '0) ? PTR_LAST : front_q - PW'(1);
	assign slot_cnt   = slot_add(front_q, count_q[PW-1:0]);
	assign slot_cntm1 = slot_add(front_q, count_m1[PW-1:0]);
	assign is_full    = (count_q == CNT_FULL);
	assign is_empty   = (count_q == '0);
	assign is_long    = (count_q > CNT_MIN4);

	assign req_ready = (state_q == dqf_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_load  = (state_q == dqf_pkg::S_FINISH) && (!rsp_valid_q || rsp_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqf_pkg::S_IDLE: begin
				if (accept) begin
					case (operation)
						dqf_pkg::OP_POP_FRONT, dqf_pkg::OP_POP_BACK: begin
							state_d = is_empty ? dqf_pkg::S_FINISH : dqf_pkg::S_POP_RD;
						end
						dqf_pkg::OP_REMOVE_FOURTH: begin
							state_d = is_long ? dqf_pkg::S_R4_A : dqf_pkg::S_FINISH;
						end
						default: begin
							state_d = dqf_pkg::S_FINISH;
						end
					endcase
				end
			end
			dqf_pkg::S_POP_RD: state_d = dqf_pkg::S_FINISH;
			dqf_pkg::S_R4_A:   state_d = dqf_pkg::S_R4_B;
			dqf_pkg::S_R4_B:   state_d = dqf_pkg::S_R4_C;
			dqf_pkg::S_R4_C:   state_d = dqf_pkg::S_R4_D;
			dqf_pkg::S_R4_D:   state_d = dqf_pkg::S_FINISH;
			dqf_pkg::S_FINISH: begin
				if (rsp_load) begin
					state_d = dqf_pkg::S_IDLE;
				end
			end
			default: state_d = dqf_pkg::S_IDLE;
		endcase
	end

	// memory control, pointer updates and result staging
	always_comb begin
		mem_we       = 1'b0;
		mem_waddr    = slot3;
		mem_wdata    = mem_rdata;
		mem_raddr    = front_q;
		front_d      = front_q;
		count_d      = count_q;
		res_load     = 1'b0;
		res_value_d  = res_value_q;
		res_rvalid_d = res_rvalid_q;
		res_status_d = res_status_q;
		unique case (state_q)
			dqf_pkg::S_IDLE: begin
				// removal of the fourth entry reads from the back end of the window
				case (operation)
					dqf_pkg::OP_POP_BACK:      mem_raddr = slot_cntm1;
					dqf_pkg::OP_REMOVE_FOURTH: mem_raddr = slot3;
					default:                   mem_raddr = front_q;
				endcase
				if (accept) begin
					res_load     = 1'b1;
					res_value_d  = '0;
					res_rvalid_d = 1'b0;
					res_status_d = dqf_pkg::ST_DONE;
					case (operation)
						dqf_pkg::OP_PUSH_FRONT, dqf_pkg::OP_PUSH_BACK: begin
							if (is_full) begin
								res_status_d = dqf_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = push_value;
								count_d   = count_q + CW'(1);
								if (operation == dqf_pkg::OP_PUSH_FRONT) begin
									mem_waddr = slot_prev;
									front_d   = slot_prev;
								end else begin
									mem_waddr = slot_cnt;
								end
							end
						end
						dqf_pkg::OP_POP_FRONT, dqf_pkg::OP_POP_BACK: begin
							if (is_empty) begin
								res_status_d = dqf_pkg::ST_SHORT;
							end
						end
						dqf_pkg::OP_REMOVE_FOURTH: begin
							if (!is_long) begin
								res_status_d = dqf_pkg::ST_SHORT;
							end
						end
						default: begin
							res_status_d = dqf_pkg::ST_DONE;
						end
					endcase
				end
			end
			dqf_pkg::S_POP_RD: begin
				res_load     = 1'b1;
				res_value_d  = mem_rdata;
				res_rvalid_d = 1'b1;
				count_d      = count_m1;
				if (op_q == dqf_pkg::OP_POP_FRONT) begin
					front_d = slot1;
				end
			end
			dqf_pkg::S_R4_A: begin
				// fourth entry arrives
				mem_raddr    = slot2;
				res_load     = 1'b1;
				res_value_d  = mem_rdata;
				res_rvalid_d = 1'b1;
			end
			dqf_pkg::S_R4_B: begin
				// third entry moves back one place
				mem_raddr = slot1;
				mem_we    = 1'b1;
				mem_waddr = slot3;
			end
			dqf_pkg::S_R4_C: begin
				mem_raddr = front_q;
				mem_we    = 1'b1;
				mem_waddr = slot2;
			end
			dqf_pkg::S_R4_D: begin
				// front entry moves back, front advances
				mem_we    = 1'b1;
				mem_waddr = slot1;
				front_d   = slot1;
				count_d   = count_m1;
			end
			dqf_pkg::S_FINISH: begin
				mem_raddr = front_q;
			end
			default: begin
				mem_raddr = front_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqf_pkg::S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
		end
		if (res_load) begin
			res_value_q  <= res_value_d;
			res_rvalid_q <= res_rvalid_d;
			res_status_q <= res_status_d;
		end
		if (rsp_load) begin
			rsp_value_q  <= res_value_q;
			rsp_rvalid_q <= res_rvalid_q;
			rsp_count_q  <= dqf_pkg::COUNT_OUT_W'(count_q);
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign removed_value = rsp_value_q;
	assign removed_valid = rsp_rvalid_q;
	assign entry_count   = rsp_count_q;
	assign status        = rsp_status_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("held count above depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != dqf_pkg::S_IDLE)
		else $error("sequencer idle right after accepting a word");

	a_removed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_rvalid_q) |-> rsp_status_q == dqf_pkg::ST_DONE)
		else $error("removed value flagged on a rejected request");

	a_no_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dqf_pkg::S_FINISH || state_q == dqf_pkg::S_POP_RD) |-> !mem_we)
		else $error("store written outside push or shift steps");

endmodule
